// ===== src/dda_line_rasterizer_defines.svh =====
// Assertion macros for the DDA line rasterizer.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define DDA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DDA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DDA_ASSERT(label, clk, rst_n, prop, msg)
`define DDA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/dda_pkg.sv =====
// Shared constants and types for the DDA line rasterizer.
// No dependencies; imported by every module of the block.
package dda_pkg;

    localparam int SCREEN_WIDTH = 1024;
    localparam int FRAC_BITS    = 16;
    localparam int COORD_W      = 10;
    localparam int POS_W        = COORD_W + FRAC_BITS + 2;
    localparam int ADDR_W       = 20;
    localparam int COLOR_W      = 32;
    localparam int LEN_W        = COORD_W + 1;
    localparam int QUOT_W       = FRAC_BITS + 1;
    localparam int CNT_W        = $clog2(FRAC_BITS);
    localparam int IN_TDATA_W   = 4 * COORD_W + COLOR_W;
    localparam int OUT_TDATA_W  = 2 * COORD_W + ADDR_W + COLOR_W;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] adx;
        logic [COORD_W-1:0] ady;
        logic               neg_x;
        logic               neg_y;
        logic [COORD_W-1:0] len;
        logic [COLOR_W-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic dividing;
        logic active;
        logic emit;
    } back_stat_t;

endpackage

// ===== src/dda_queue.sv =====
// Short command queue between the front and back halves.
// Depends on dda_pkg.
module dda_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  dda_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output dda_pkg::cmd_t out_cmd
);
    import dda_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== src/dda_front.sv =====
// Front half: accepts input transfers, works out deltas and line length.
// Depends on dda_pkg and dda_queue.
module dda_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dda_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    output logic                           q_valid,
    input  logic                           q_ready,
    output dda_pkg::cmd_t                  q_cmd
);
    import dda_pkg::*;

    logic [COORD_W-1:0] x0, y0, x1, y1, adx, ady;
    logic               neg_x, neg_y;
    cmd_t               cmd;

    assign x0 = s_tdata[0*COORD_W +: COORD_W];
    assign y0 = s_tdata[1*COORD_W +: COORD_W];
    assign x1 = s_tdata[2*COORD_W +: COORD_W];
    assign y1 = s_tdata[3*COORD_W +: COORD_W];

    always_comb begin
        neg_x     = (x1 < x0);
        neg_y     = (y1 < y0);
        adx       = neg_x ? x0 - x1 : x1 - x0;
        ady       = neg_y ? y0 - y1 : y1 - y0;
        cmd.op    = s_tuser;
        cmd.x0    = x0;
        cmd.y0    = y0;
        cmd.adx   = adx;
        cmd.ady   = ady;
        cmd.neg_x = neg_x;
        cmd.neg_y = neg_y;
        cmd.len   = (adx >= ady) ? adx : ady;
        cmd.color = s_tdata[4*COORD_W +: COLOR_W];
    end

    dda_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

endmodule

// ===== src/dda_back.sv =====
// Back half: step divider, position accumulators and pixel output register.
// Depends on dda_pkg.
module dda_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  dda_pkg::cmd_t                   q_cmd,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dda_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    output dda_pkg::back_stat_t             stat
);
    import dda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;

    localparam logic [POS_W-1:0] HALF = POS_W'(1) << (FRAC_BITS - 1);

    function automatic logic [COORD_W-1:0] round_pos(input logic [POS_W-1:0] p);
        logic [POS_W-1:0]   mag_src;
        logic [POS_W-1:0]   sum;
        logic [COORD_W-1:0] mag;
        mag_src = p[POS_W-1] ? (~p + 1'b1) : p;
        sum     = mag_src + HALF;
        mag     = sum[FRAC_BITS +: COORD_W];
        return p[POS_W-1] ? (~mag + 1'b1) : mag;
    endfunction

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [LEN_W-1:0]       left_reg, left_next;
    logic                   m_valid_reg, m_valid_next;
    logic [COORD_W-1:0]     rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [QUOT_W-1:0]      qx_reg, qx_next, qy_reg, qy_next;
    logic                   neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [COORD_W-1:0]     len_reg, len_next;
    logic [POS_W-1:0]       pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [POS_W-1:0]       step_x_reg, step_x_next, step_y_reg, step_y_next;
    logic [COLOR_W-1:0]     color_reg, color_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;

    logic               out_free, pop, emit, ix, iy, bx, by;
    logic [COORD_W:0]   rx2, ry2;
    logic [COORD_W-1:0] px, py;
    logic [ADDR_W-1:0]  addr;

    always_comb begin
        out_free = !m_valid_reg || m_tready;
        pop      = q_valid && (state_reg == ST_IDLE)
                   && (q_cmd.op == OP_START || left_reg == '0 || out_free);
        emit     = pop && (q_cmd.op == OP_STEP) && (left_reg != '0);

        rx2 = {rem_x_reg, 1'b0};
        ry2 = {rem_y_reg, 1'b0};
        bx  = (rx2 >= {1'b0, len_reg});
        by  = (ry2 >= {1'b0, len_reg});
        ix  = (q_cmd.adx == q_cmd.len);
        iy  = (q_cmd.ady == q_cmd.len);

        px   = round_pos(pos_x_reg);
        py   = round_pos(pos_y_reg);
        addr = ADDR_W'(ADDR_W'(py) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(px);

        state_next   = state_reg;
        cnt_next     = cnt_reg;
        left_next    = left_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        rem_x_next   = rem_x_reg;
        rem_y_next   = rem_y_reg;
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        len_next     = len_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        color_next   = color_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (pop && q_cmd.op == OP_START) begin
                    pos_x_next = POS_W'(q_cmd.x0) << FRAC_BITS;
                    pos_y_next = POS_W'(q_cmd.y0) << FRAC_BITS;
                    color_next = q_cmd.color;
                    neg_x_next = q_cmd.neg_x;
                    neg_y_next = q_cmd.neg_y;
                    len_next   = q_cmd.len;
                    rem_x_next = ix ? '0 : q_cmd.adx;
                    rem_y_next = iy ? '0 : q_cmd.ady;
                    qx_next    = QUOT_W'(ix);
                    qy_next    = QUOT_W'(iy);
                    cnt_next   = '0;
                    left_next  = LEN_W'(q_cmd.len);
                    if (q_cmd.len != '0) begin
                        state_next = ST_DIV;
                    end
                end else if (emit) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {color_reg, addr, py, px};
                    m_last_next  = (left_reg == LEN_W'(1));
                    pos_x_next   = pos_x_reg + step_x_reg;
                    pos_y_next   = pos_y_reg + step_y_reg;
                    left_next    = left_reg - 1'b1;
                end
            end
            ST_DIV: begin
                rem_x_next = bx ? COORD_W'(rx2 - {1'b0, len_reg}) : COORD_W'(rx2);
                rem_y_next = by ? COORD_W'(ry2 - {1'b0, len_reg}) : COORD_W'(ry2);
                qx_next    = {qx_reg[QUOT_W-2:0], bx};
                qy_next    = {qy_reg[QUOT_W-2:0], by};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS - 1)) begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN: begin
                step_x_next = neg_x_reg ? POS_W'(0) - POS_W'(qx_reg) : POS_W'(qx_reg);
                step_y_next = neg_y_reg ? POS_W'(0) - POS_W'(qy_reg) : POS_W'(qy_reg);
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_x_reg  <= rem_x_next;
        rem_y_reg  <= rem_y_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        len_reg    <= len_next;
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
        step_x_reg <= step_x_next;
        step_y_reg <= step_y_next;
        color_reg  <= color_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign q_ready       = pop;
    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = m_data_reg;
    assign m_tlast       = m_last_reg;
    assign stat.dividing = (state_reg != ST_IDLE);
    assign stat.active   = (left_reg != '0);
    assign stat.emit     = emit;

endmodule

// ===== src/dda_line_rasterizer.sv =====
// DDA line rasterizer top level: front classifier, command queue, back end.
// Depends on dda_pkg, dda_front, dda_back and the assertion macro header.
//
// A start transfer (tuser low) latches the start point, deltas and color;
// a step transfer (tuser high) emits one pixel while a line is active, with
// tlast on its final pixel. Step transfers run at one pixel per clock,
// limited by the output register. A start loads in ST_IDLE, then ST_DIV runs
// a shift-subtract divide per axis forming both Q.16 steps (one quotient bit
// per cycle), then ST_SIGN applies signs. Up to four transfers queue ahead of
// the back end, so the input keeps accepting while a divide runs.
`include "dda_line_rasterizer_defines.svh"
module dda_line_rasterizer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_x, start_y, end_x, end_y, line_color
    input  logic [dda_pkg::IN_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_x, pixel_y, pixel_address, pixel_color
    output logic [dda_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import dda_pkg::*;

    logic       q_valid, q_ready;
    cmd_t       q_cmd;
    back_stat_t stat;

    dda_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    dda_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

    `DDA_ASSERT_IMPL(a_no_pop_in_divide, aclk, aresetn, q_valid && q_ready, !stat.dividing, "queue popped during divide")
    `DDA_ASSERT_IMPL(a_emit_needs_line, aclk, aresetn, stat.emit, stat.active && q_cmd.op == OP_STEP, "pixel emitted without active line")
    `DDA_ASSERT_NEXT(a_emit_shows, aclk, aresetn, stat.emit, m_tvalid, "emitted pixel not presented")

endmodule
